[sv/ucb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ucb_pkg: shared types and constants of the UCB1 arm selector
// Item kinds, register indexes, field widths and the controller state type.
// ---------------------------------------------------------------------------
package ucb_pkg;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_EXPLORE = 2'd0;
  localparam logic [1:0] REG_ARMS    = 2'd1;

  localparam int CNT_W   = 24;
  localparam int SUM_W   = 32;
  localparam int SCORE_W = 24;
  localparam int DIV_W   = 40;
  localparam int ROOT_W  = 20;
  localparam int LN_W    = 21;
  localparam int AVG_W   = 26;

  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
  localparam logic [11:0]      EXPLORE_RST = 12'd362;
  localparam logic [4:0]       ARMS_RST    = 5'd16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SEL_MOD,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_LN_SQFIX,
    ST_LN_MUL,
    ST_ARM_RD,
    ST_ARM_CHK,
    ST_DIV_AVG,
    ST_AVG_FIX,
    ST_DIV_RAT,
    ST_SQRT,
    ST_BONUS,
    ST_SCORE,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

[sv/ucb_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ucb_in_if: input item channel
// Valid/ready channel carrying one clear, update or select item.
// ---------------------------------------------------------------------------
interface ucb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  arm_index;
  logic signed [9:0] reward;
  logic [23:0] total_games;
  logic [3:0]  start_offset;

  modport source (output valid, kind, arm_index, reward, total_games, start_offset,
                  input ready);
  modport sink   (input valid, kind, arm_index, reward, total_games, start_offset,
                  output ready);
endinterface

[sv/ucb_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ucb_out_if: result channel
// Valid/ready channel carrying the chosen arm and its score.
// ---------------------------------------------------------------------------
interface ucb_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  best_arm;
  logic        was_unplayed;
  logic signed [23:0] best_score;

  modport source (output valid, best_arm, was_unplayed, best_score, input ready);
  modport sink   (input valid, best_arm, was_unplayed, best_score, output ready);
endinterface

[sv/ucb_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ucb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ---------------------------------------------------------------------------
module ucb_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[sv/ucb_arm_selector.sv]
`timescale 1ns / 1ps
// Clear empties the table as it is taken; update reads the entry (ST_UPD_RD) and
//   writes it back (ST_UPD_WR); select reduces the offset, takes the logarithm, then scores arms.
// One item at a time: the logarithm (16 bit-serial squarings) and, per arm, two
//   40-step serial divisions and a 20-step square root make up a select.
// Reset (rst_n low, synchronous): all arms read as unplayed, explore_factor = 362,
//   active_arms = 16, no result pending.
// ---------------------------------------------------------------------------
// ucb_arm_selector: UCB1 bandit arm selection
// Per-arm play count and reward sum table, with a bit-serial scoring datapath
// (log, divide, square root) that scans the active arms for the best score.
// ---------------------------------------------------------------------------
module ucb_arm_selector #(
  parameter int MAX_ARMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ucb_in_if.sink      in_ch,
  ucb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_wdata
);
  import ucb_pkg::*;

  localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int PW = (AW > 5) ? AW : 5;
  localparam int EW = CNT_W + SUM_W;

  state_t state_r, state_nxt;

  // configuration
  logic [11:0] ef_r;
  logic [4:0]  arms_r;

  // table occupancy: an entry not marked reads as zero
  logic [MAX_ARMS-1:0] valid_r;
  logic                vld_rd_r;

  // latched item
  logic [AW-1:0]     arm_r;
  logic signed [9:0] reward_r;
  logic [23:0]       total_r;

  // scan
  logic [4:0]    n_r;
  logic [PW-1:0] pos_r;
  logic [4:0]    vis_r;

  // logarithm
  logic [30:0] m_r;
  logic [4:0]  e_r;
  logic [61:0] acc_r;
  logic [30:0] mq_r;
  logic [5:0]  step_r;
  logic [3:0]  sqi_r;
  logic [15:0] lgf_r;
  logic [LN_W-1:0] lg_r;
  logic [LN_W-1:0] ln_r;

  // per-arm scoring
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic [DIV_W-1:0]        div_r;
  logic [CNT_W-1:0]        drem_r;
  logic signed [AVG_W-1:0] avg_r;
  logic [ROOT_W-1:0]       root_r;
  logic [21:0]             srem_r;
  logic [23:0]             bonus_r;

  // running best and output register
  logic                      have_r;
  logic [3:0]                best_pos_r;
  logic signed [SCORE_W-1:0] best_sc_r;
  logic                      unpl_r;
  logic                      ovalid_r;
  logic [3:0]                ob_arm_r;
  logic                      ob_unpl_r;
  logic signed [SCORE_W-1:0] ob_score_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic in_fire, out_fire, out_load;

  // ------------------------------------------------------------------
  // Combinational datapath pieces
  // ------------------------------------------------------------------
  logic [CNT_W-1:0]       ent_cnt;
  logic signed [SUM_W-1:0] ent_sum;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic [4:0]              n_clamp, arms_nz;

  logic [CNT_W:0]    dsh;
  logic              dge;
  logic [CNT_W-1:0]  drem_nxt;

  logic [23:0] ssh;
  logic [23:0] strial;
  logic        sge;

  logic [61:0] sq_nxt;
  logic [31:0] sq_t;
  logic [52:0] mul_nxt;

  logic [31:0]             abs_sum;
  logic signed [AVG_W-1:0] avg_val;
  logic [31:0]             bprod;
  logic signed [AVG_W:0]   s_wide;
  logic signed [SCORE_W-1:0] s_sat;

  assign ent_cnt = vld_rd_r ? ram_rdata[EW-1:SUM_W] : '0;
  assign ent_sum = vld_rd_r ? $signed(ram_rdata[SUM_W-1:0]) : '0;

  // saturating accumulate of one Q1.8 reward
  always_comb begin
    sum_ext = {ent_sum[SUM_W-1], ent_sum} + (SUM_W+1)'(reward_r);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // arm count for the scan: zero means one, cap at the table size
  assign arms_nz = (arms_r == 5'd0) ? 5'd1 : arms_r;
  assign n_clamp = (int'(arms_nz) > MAX_ARMS) ? 5'(MAX_ARMS) : arms_nz;

  // one restoring-division step
  assign dsh      = {drem_r, div_r[DIV_W-1]};
  assign dge      = dsh >= {1'b0, cnt_r};
  assign drem_nxt = dge ? CNT_W'(dsh - {1'b0, cnt_r}) : dsh[CNT_W-1:0];

  // one square-root digit step
  assign ssh    = {srem_r, div_r[DIV_W-1 -: 2]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = ssh >= strial;

  // serial squaring and log2 * ln2 accumulate, MSB first
  assign sq_nxt  = {acc_r[60:0], 1'b0} + (mq_r[30] ? {31'd0, m_r} : 62'd0);
  assign sq_t    = acc_r[61:30];
  assign mul_nxt = {acc_r[51:0], 1'b0} + (lg_r[LN_W-1] ? {21'd0, LN2_Q32} : 53'd0);

  // average: magnitude quotient back to signed, clamped to a range that keeps
  // the final saturation exact
  assign abs_sum = ent_sum[SUM_W-1] ? 32'(-ent_sum) : 32'(ent_sum);
  always_comb begin
    if (neg_r) begin
      if (div_r >= DIV_W'(33554432)) begin
        avg_val = {1'b1, {(AVG_W-1){1'b0}}};
      end else begin
        avg_val = $signed(~{1'b0, div_r[AVG_W-2:0]} + AVG_W'(1));
      end
    end else begin
      if (div_r >= DIV_W'(33554431)) begin
        avg_val = {1'b0, {(AVG_W-1){1'b1}}};
      end else begin
        avg_val = $signed({1'b0, div_r[AVG_W-2:0]});
      end
    end
  end

  assign bprod  = 32'(ef_r) * 32'(root_r);
  assign s_wide = (AVG_W+1)'(avg_r) + $signed({3'b000, bonus_r});
  always_comb begin
    if (s_wide > (AVG_W+1)'(8388607)) begin
      s_sat = {1'b0, {(SCORE_W-1){1'b1}}};
    end else if (s_wide < -(AVG_W+1)'(8388608)) begin
      s_sat = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      s_sat = s_wide[SCORE_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.kind)
            KIND_UPDATE: begin
              if (int'(in_ch.arm_index) < MAX_ARMS) begin
                state_nxt = ST_UPD_RD;
              end
            end
            KIND_SELECT: state_nxt = ST_SEL_MOD;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPD_RD:  state_nxt = ST_UPD_WR;
      ST_UPD_WR:  state_nxt = ST_IDLE;
      ST_SEL_MOD: begin
        if (pos_r < PW'(n_r)) begin
          state_nxt = (total_r == 24'd0) ? ST_ARM_RD : ST_LN_NORM;
        end
      end
      ST_LN_NORM:  if (m_r[30]) state_nxt = ST_LN_SQ;
      ST_LN_SQ:    if (step_r == 6'd30) state_nxt = ST_LN_SQFIX;
      ST_LN_SQFIX: state_nxt = (sqi_r == 4'd0) ? ST_LN_MUL : ST_LN_SQ;
      ST_LN_MUL:   if (step_r == 6'd20) state_nxt = ST_ARM_RD;
      ST_ARM_RD:   state_nxt = ST_ARM_CHK;
      ST_ARM_CHK:  state_nxt = (ent_cnt == '0) ? ST_DONE : ST_DIV_AVG;
      ST_DIV_AVG:  if (step_r == 6'(DIV_W-1)) state_nxt = ST_AVG_FIX;
      ST_AVG_FIX:  state_nxt = ST_DIV_RAT;
      ST_DIV_RAT:  if (step_r == 6'(DIV_W-1)) state_nxt = ST_SQRT;
      ST_SQRT:     if (step_r == 6'(ROOT_W-1)) state_nxt = ST_BONUS;
      ST_BONUS:    state_nxt = ST_SCORE;
      ST_SCORE:    state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = (vis_r + 5'd1 == n_r) ? ST_DONE : ST_ARM_RD;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Outputs of the controller
  // ------------------------------------------------------------------
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    out_load    = (state_r == ST_DONE) && (!ovalid_r || out_ch.ready);
    ram_we      = (state_r == ST_UPD_WR) && (ent_cnt != COUNT_MAX);
    ram_waddr   = arm_r;
    ram_wdata   = {ent_cnt + CNT_W'(1), sum_sat};
    ram_raddr   = (state_r == ST_UPD_RD) ? arm_r : AW'(pos_r);
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  ucb_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ARMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ef_r     <= EXPLORE_RST;
      arms_r   <= ARMS_RST;
      valid_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_EXPLORE: ef_r   <= cfg_wdata;
          REG_ARMS:    arms_r <= cfg_wdata[4:0];
          default:     ;
        endcase
      end
      // clear drops every entry at once
      if (in_fire && in_ch.kind == KIND_CLEAR) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_fire) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    vld_rd_r <= valid_r[ram_raddr];
    case (state_r)
      ST_IDLE: begin
        arm_r    <= AW'(in_ch.arm_index);
        reward_r <= in_ch.reward;
        total_r  <= in_ch.total_games;
        pos_r    <= PW'(in_ch.start_offset);
        n_r      <= n_clamp;
        vis_r    <= '0;
        have_r   <= 1'b0;
        unpl_r   <= 1'b0;
        ln_r     <= '0;
        m_r      <= {in_ch.total_games, 7'd0};
        e_r      <= 5'd23;
      end
      ST_SEL_MOD: begin
        // reduce the offset by repeated subtraction
        if (pos_r >= PW'(n_r)) begin
          pos_r <= pos_r - PW'(n_r);
        end
      end
      ST_LN_NORM: begin
        if (m_r[30]) begin
          acc_r  <= '0;
          mq_r   <= m_r;
          step_r <= '0;
          sqi_r  <= 4'd15;
        end else begin
          m_r <= {m_r[29:0], 1'b0};
          e_r <= e_r - 5'd1;
        end
      end
      ST_LN_SQ: begin
        acc_r  <= sq_nxt;
        mq_r   <= {mq_r[29:0], 1'b0};
        step_r <= step_r + 6'd1;
      end
      ST_LN_SQFIX: begin
        lgf_r <= {lgf_r[14:0], sq_t[31]};
        m_r   <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        mq_r  <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        acc_r <= '0;
        step_r <= '0;
        sqi_r <= sqi_r - 4'd1;
        lg_r  <= {e_r, lgf_r[14:0], sq_t[31]};
      end
      ST_LN_MUL: begin
        acc_r  <= {9'd0, mul_nxt};
        lg_r   <= {lg_r[LN_W-2:0], 1'b0};
        step_r <= step_r + 6'd1;
        if (step_r == 6'd20) begin
          ln_r <= mul_nxt[52:32];
        end
      end
      ST_ARM_CHK: begin
        cnt_r  <= ent_cnt;
        neg_r  <= ent_sum[SUM_W-1];
        // load |sum| * 256 as the dividend of the average
        div_r  <= {abs_sum, 8'd0};
        drem_r <= '0;
        step_r <= '0;
        if (ent_cnt == '0) begin
          best_pos_r <= pos_r[3:0];
          best_sc_r  <= '0;
          unpl_r     <= 1'b1;
        end
      end
      ST_DIV_AVG, ST_DIV_RAT: begin
        div_r  <= {div_r[DIV_W-2:0], dge};
        drem_r <= drem_nxt;
        if (state_r == ST_DIV_RAT && step_r == 6'(DIV_W-1)) begin
          srem_r <= '0;
          root_r <= '0;
          step_r <= '0;
        end else begin
          step_r <= step_r + 6'd1;
        end
      end
      ST_AVG_FIX: begin
        avg_r  <= avg_val;
        div_r  <= {3'd0, ln_r, 16'd0};
        drem_r <= '0;
        step_r <= '0;
      end
      ST_SQRT: begin
        srem_r <= sge ? 22'(ssh - strial) : ssh[21:0];
        root_r <= {root_r[ROOT_W-2:0], sge};
        div_r  <= {div_r[DIV_W-3:0], 2'b00};
        step_r <= step_r + 6'd1;
      end
      ST_BONUS: begin
        bonus_r <= bprod[31:8];
      end
      ST_SCORE: begin
        // strict compare keeps ties on the arm met first
        if (!have_r || s_sat > best_sc_r) begin
          have_r     <= 1'b1;
          best_pos_r <= pos_r[3:0];
          best_sc_r  <= s_sat;
        end
      end
      ST_NEXT: begin
        vis_r <= vis_r + 5'd1;
        pos_r <= (pos_r + PW'(1) == PW'(n_r)) ? '0 : pos_r + PW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      ob_arm_r   <= best_pos_r;
      ob_unpl_r  <= unpl_r;
      ob_score_r <= best_sc_r;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.best_arm     = ob_arm_r;
  assign out_ch.was_unplayed = ob_unpl_r;
  assign out_ch.best_score   = ob_score_r;

endmodule

[sv/ucb_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ucb_chk: port-level checks of the UCB1 arm selector
// Watches the item and result channels; bound to the top level.
// ---------------------------------------------------------------------------
module ucb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_unplayed,
  input logic [23:0] out_score
);
  import ucb_pkg::*;

  // a pending result holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // an unplayed pick carries a zero score
  a_unpl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unplayed |-> out_score == 24'd0)
    else $error("unplayed arm with nonzero score");

  // clear and update never produce a result right away
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind != KIND_SELECT |=> !$rose(out_valid))
    else $error("result after a non-select item");

  // a select keeps the block busy
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_SELECT |=> !in_ready)
    else $error("input taken during a select");
endmodule

bind ucb_arm_selector ucb_chk u_ucb_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_kind      (in_ch.kind),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_unplayed (out_ch.was_unplayed),
  .out_score    (out_ch.best_score)
);
